/* hw/rtl/mwfcd_pkg.sv */
// Shared types and constants of the mutex wait-for cycle detector.
package mwfcd_pkg;

    localparam logic [1:0] KIND_LOCK_ENTER = 2'd0;
    localparam logic [1:0] KIND_LOCK_EXIT  = 2'd1;
    localparam logic [1:0] KIND_UNLOCK     = 2'd2;

    // Most edges one detected cycle can report.
    localparam int RESULT_CAP = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SADDR,
        ST_SCMP,
        ST_ACT,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_ENTER_WAIT,
        PH_WALK_OWN,
        PH_WALK_WAIT,
        PH_EXIT_WAIT,
        PH_EXIT_OWN,
        PH_UNLOCK
    } phase_t;

    typedef struct packed {
        logic load_item;
        logic tbl_owner;
        logic scan_clr;
        logic scan_inc;
        logic note_free;
        logic mark_hit;
        logic wait_write;
        logic owner_write;
        logic wait_clr;
        logic owner_clr;
        logic mutex_from_hit;
        logic thread_from_hit;
        logic hop_clr;
        logic hop_store;
        logic hop_inc;
        logic out_k_clr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       filtered;
        logic [1:0] kind;
        logic       lock_ok;
        logic       ent_valid;
        logic       key_match;
        logic       idx_last;
        logic       found;
        logic       free_found;
        logic       own_is_root;
        logic       hop_at_limit;
        logic       out_free;
        logic       out_is_last;
    } sts_t;

endpackage

/* hw/rtl/mwfcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mwfcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/mwfcd_datapath.sv */
// Datapath: item and config registers, both tables, scan counter, hop store, result register.
module mwfcd_datapath #(
    parameter int OWNER_ENTRIES = 64,
    parameter int WAIT_ENTRIES  = 64,
    parameter int HOP_LIMIT     = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mwfcd_pkg::cmd_t     cmd,
    output mwfcd_pkg::sts_t     sts,
    input  logic                cfg_valid,
    input  logic [31:0]         cfg_target_process,
    input  logic [1:0]          s_kind,
    input  logic [31:0]         s_thread_id,
    input  logic [31:0]         s_process_id,
    input  logic [63:0]         s_mutex_addr,
    input  logic                s_lock_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_root_thread,
    output logic [31:0]         m_report_process,
    output logic [2:0]          m_chain_depth,
    output logic [2:0]          m_hop_index,
    output logic [31:0]         m_hop_thread,
    output logic [63:0]         m_hop_mutex,
    output logic                m_last
);

    localparam int OW    = $clog2(OWNER_ENTRIES);
    localparam int WW    = $clog2(WAIT_ENTRIES);
    localparam int IDX_W = (OW > WW) ? OW : WW;
    localparam int WALK_LIMIT = (HOP_LIMIT + 1 < mwfcd_pkg::RESULT_CAP) ?
                                (HOP_LIMIT + 1) : mwfcd_pkg::RESULT_CAP;

    logic [31:0] target_reg;
    logic [1:0]  kind_reg;
    logic [31:0] tid_reg;
    logic [31:0] pid_reg;
    logic        ok_reg;
    logic [63:0] cur_mutex_reg;
    logic [31:0] cur_thread_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             found_reg;
    logic             free_found_reg;
    logic [31:0]      hit_thread_reg;
    logic [63:0]      hit_mutex_reg;

    logic [OWNER_ENTRIES-1:0] owner_valid_reg;
    logic [WAIT_ENTRIES-1:0]  wait_valid_reg;

    logic [2:0]  hop_reg;
    logic [2:0]  out_k_reg;
    logic [31:0] hop_thread_reg [mwfcd_pkg::RESULT_CAP];
    logic [63:0] hop_mutex_reg  [mwfcd_pkg::RESULT_CAP];

    logic        m_valid_reg;
    logic [2:0]  m_depth_reg;
    logic [2:0]  m_index_reg;
    logic [31:0] m_hop_thread_reg;
    logic [63:0] m_hop_mutex_reg;
    logic        m_last_reg;
    logic [31:0] m_root_reg;
    logic [31:0] m_proc_reg;

    logic [95:0]   owner_rdata;
    logic [95:0]   wait_rdata;
    logic [OW-1:0] owner_waddr;
    logic [WW-1:0] wait_waddr;
    logic [OW-1:0] owner_sel;
    logic [WW-1:0] wait_sel;

    assign owner_sel   = found_reg ? hit_idx_reg[OW-1:0] : free_idx_reg[OW-1:0];
    assign wait_sel    = found_reg ? hit_idx_reg[WW-1:0] : free_idx_reg[WW-1:0];
    assign owner_waddr = owner_sel;
    assign wait_waddr  = wait_sel;

    // Owner entries hold {mutex key, owner thread}; wait entries hold {thread key, mutex}.
    mwfcd_ram #(.WIDTH(96), .DEPTH(OWNER_ENTRIES)) u_owner_ram (
        .aclk  (aclk),
        .we    (cmd.owner_write),
        .waddr (owner_waddr),
        .wdata ({cur_mutex_reg, tid_reg}),
        .raddr (idx_reg[OW-1:0]),
        .rdata (owner_rdata)
    );

    mwfcd_ram #(.WIDTH(96), .DEPTH(WAIT_ENTRIES)) u_wait_ram (
        .aclk  (aclk),
        .we    (cmd.wait_write),
        .waddr (wait_waddr),
        .wdata ({cur_thread_reg, cur_mutex_reg}),
        .raddr (idx_reg[WW-1:0]),
        .rdata (wait_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= '0;
            owner_valid_reg <= '0;
            wait_valid_reg  <= '0;
            m_valid_reg     <= 1'b0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            hop_reg         <= '0;
            out_k_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                target_reg <= cfg_target_process;
            end
            if (cmd.scan_clr) begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (cmd.scan_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.mark_hit) begin
                found_reg <= 1'b1;
            end
            if (cmd.note_free && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
            if (cmd.owner_write && !found_reg) begin
                owner_valid_reg[owner_sel] <= 1'b1;
            end
            if (cmd.owner_clr) begin
                owner_valid_reg[hit_idx_reg[OW-1:0]] <= 1'b0;
            end
            if (cmd.wait_write && !found_reg) begin
                wait_valid_reg[wait_sel] <= 1'b1;
            end
            if (cmd.wait_clr) begin
                wait_valid_reg[hit_idx_reg[WW-1:0]] <= 1'b0;
            end
            if (cmd.hop_clr) begin
                hop_reg <= '0;
            end else if (cmd.hop_inc) begin
                hop_reg <= hop_reg + 3'd1;
            end
            if (cmd.out_k_clr) begin
                out_k_reg <= '0;
            end else if (cmd.out_load) begin
                out_k_reg <= out_k_reg + 3'd1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg       <= s_kind;
            tid_reg        <= s_thread_id;
            pid_reg        <= s_process_id;
            ok_reg         <= s_lock_ok;
            cur_mutex_reg  <= s_mutex_addr;
            cur_thread_reg <= s_thread_id;
        end
        if (cmd.mutex_from_hit) begin
            cur_mutex_reg <= hit_mutex_reg;
        end
        if (cmd.thread_from_hit) begin
            cur_thread_reg <= hit_thread_reg;
        end
        if (cmd.mark_hit) begin
            hit_idx_reg    <= idx_reg;
            hit_thread_reg <= owner_rdata[31:0];
            hit_mutex_reg  <= wait_rdata[63:0];
        end
        if (cmd.note_free && !free_found_reg) begin
            free_idx_reg <= idx_reg;
        end
        if (cmd.hop_store) begin
            hop_thread_reg[hop_reg] <= hit_thread_reg;
            hop_mutex_reg[hop_reg]  <= cur_mutex_reg;
        end
        if (cmd.out_load) begin
            m_root_reg       <= tid_reg;
            m_proc_reg       <= pid_reg;
            m_depth_reg      <= hop_reg + 3'd1;
            m_index_reg      <= out_k_reg;
            m_hop_thread_reg <= hop_thread_reg[out_k_reg];
            m_hop_mutex_reg  <= hop_mutex_reg[out_k_reg];
            m_last_reg       <= (out_k_reg == hop_reg);
        end
    end

    always_comb begin
        sts.filtered     = (target_reg != '0) && (pid_reg != target_reg);
        sts.kind         = kind_reg;
        sts.lock_ok      = ok_reg;
        sts.ent_valid    = cmd.tbl_owner ? owner_valid_reg[idx_reg[OW-1:0]]
                                         : wait_valid_reg[idx_reg[WW-1:0]];
        sts.key_match    = cmd.tbl_owner ? (owner_rdata[95:32] == cur_mutex_reg)
                                         : (wait_rdata[95:64] == cur_thread_reg);
        sts.idx_last     = cmd.tbl_owner ?
                           (idx_reg == IDX_W'(OWNER_ENTRIES - 1)) :
                           (idx_reg == IDX_W'(WAIT_ENTRIES - 1));
        sts.found        = found_reg;
        sts.free_found   = free_found_reg;
        sts.own_is_root  = (hit_thread_reg == tid_reg);
        sts.hop_at_limit = (hop_reg == 3'(WALK_LIMIT - 1));
        sts.out_free     = !m_valid_reg || m_ready;
        sts.out_is_last  = (out_k_reg == hop_reg);
    end

    assign m_valid          = m_valid_reg;
    assign m_root_thread    = m_root_reg;
    assign m_report_process = m_proc_reg;
    assign m_chain_depth    = m_depth_reg;
    assign m_hop_index      = m_index_reg;
    assign m_hop_thread     = m_hop_thread_reg;
    assign m_hop_mutex      = m_hop_mutex_reg;
    assign m_last           = m_last_reg;

`ifndef NO_ASSERTIONS
    a_hop_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hop_reg <= 3'(WALK_LIMIT - 1))
        else $error("hop counter ran past the walk limit");
    a_out_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && !cmd.out_k_clr |=> m_index_reg == $past(out_k_reg))
        else $error("result beat carries the wrong hop index");
`endif

endmodule

/* hw/rtl/mwfcd_ctrl.sv */
// Controller: sequences table scans, table updates, the chain walk and result beats.
module mwfcd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mwfcd_pkg::sts_t sts,
    output mwfcd_pkg::cmd_t cmd
);

    mwfcd_pkg::state_t state_reg, state_next;
    mwfcd_pkg::phase_t phase_reg, phase_next;
    logic              tbl_owner;

    assign tbl_owner = (phase_reg == mwfcd_pkg::PH_WALK_OWN) ||
                       (phase_reg == mwfcd_pkg::PH_EXIT_OWN) ||
                       (phase_reg == mwfcd_pkg::PH_UNLOCK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mwfcd_pkg::ST_IDLE;
            phase_reg <= mwfcd_pkg::PH_ENTER_WAIT;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            mwfcd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mwfcd_pkg::ST_CHECK;
                end
            end
            mwfcd_pkg::ST_CHECK: begin
                state_next = mwfcd_pkg::ST_SADDR;
                if (sts.filtered) begin
                    state_next = mwfcd_pkg::ST_IDLE;
                end else if (sts.kind == mwfcd_pkg::KIND_LOCK_ENTER) begin
                    phase_next = mwfcd_pkg::PH_ENTER_WAIT;
                end else if (sts.kind == mwfcd_pkg::KIND_LOCK_EXIT) begin
                    phase_next = mwfcd_pkg::PH_EXIT_WAIT;
                end else if (sts.kind == mwfcd_pkg::KIND_UNLOCK) begin
                    phase_next = mwfcd_pkg::PH_UNLOCK;
                end else begin
                    state_next = mwfcd_pkg::ST_IDLE;
                end
            end
            mwfcd_pkg::ST_SADDR: begin
                if (sts.ent_valid) begin
                    state_next = mwfcd_pkg::ST_SCMP;
                end else if (sts.idx_last) begin
                    state_next = mwfcd_pkg::ST_ACT;
                end
            end
            mwfcd_pkg::ST_SCMP: begin
                if (sts.key_match || sts.idx_last) begin
                    state_next = mwfcd_pkg::ST_ACT;
                end else begin
                    state_next = mwfcd_pkg::ST_SADDR;
                end
            end
            mwfcd_pkg::ST_ACT: begin
                state_next = mwfcd_pkg::ST_IDLE;
                unique case (phase_reg)
                    mwfcd_pkg::PH_ENTER_WAIT: begin
                        phase_next = mwfcd_pkg::PH_WALK_OWN;
                        state_next = mwfcd_pkg::ST_SADDR;
                    end
                    mwfcd_pkg::PH_WALK_OWN: begin
                        if (sts.found && sts.own_is_root) begin
                            state_next = mwfcd_pkg::ST_EMIT;
                        end else if (sts.found && !sts.hop_at_limit) begin
                            phase_next = mwfcd_pkg::PH_WALK_WAIT;
                            state_next = mwfcd_pkg::ST_SADDR;
                        end
                    end
                    mwfcd_pkg::PH_WALK_WAIT: begin
                        if (sts.found) begin
                            phase_next = mwfcd_pkg::PH_WALK_OWN;
                            state_next = mwfcd_pkg::ST_SADDR;
                        end
                    end
                    mwfcd_pkg::PH_EXIT_WAIT: begin
                        if (sts.found && sts.lock_ok) begin
                            phase_next = mwfcd_pkg::PH_EXIT_OWN;
                            state_next = mwfcd_pkg::ST_SADDR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mwfcd_pkg::ST_EMIT: begin
                if (sts.out_free && sts.out_is_last) begin
                    state_next = mwfcd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mwfcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.tbl_owner = tbl_owner;
        s_ready       = 1'b0;
        unique case (state_reg)
            mwfcd_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            mwfcd_pkg::ST_CHECK: begin
                cmd.scan_clr = 1'b1;
            end
            mwfcd_pkg::ST_SADDR: begin
                if (!sts.ent_valid) begin
                    cmd.note_free = 1'b1;
                    cmd.scan_inc  = !sts.idx_last;
                end
            end
            mwfcd_pkg::ST_SCMP: begin
                cmd.mark_hit = sts.key_match;
                cmd.scan_inc = !sts.key_match && !sts.idx_last;
            end
            mwfcd_pkg::ST_ACT: begin
                unique case (phase_reg)
                    mwfcd_pkg::PH_ENTER_WAIT: begin
                        // A full table drops the wait, but the walk still runs.
                        cmd.wait_write = sts.found || sts.free_found;
                        cmd.scan_clr   = 1'b1;
                        cmd.hop_clr    = 1'b1;
                    end
                    mwfcd_pkg::PH_WALK_OWN: begin
                        cmd.hop_store = sts.found;
                        if (sts.found && sts.own_is_root) begin
                            cmd.out_k_clr = 1'b1;
                        end else if (sts.found && !sts.hop_at_limit) begin
                            cmd.thread_from_hit = 1'b1;
                            cmd.scan_clr        = 1'b1;
                        end
                    end
                    mwfcd_pkg::PH_WALK_WAIT: begin
                        cmd.mutex_from_hit = sts.found;
                        cmd.hop_inc        = sts.found;
                        cmd.scan_clr       = sts.found;
                    end
                    mwfcd_pkg::PH_EXIT_WAIT: begin
                        cmd.wait_clr       = sts.found;
                        cmd.mutex_from_hit = sts.found;
                        cmd.scan_clr       = sts.found && sts.lock_ok;
                    end
                    mwfcd_pkg::PH_EXIT_OWN: begin
                        cmd.owner_write = sts.found || sts.free_found;
                    end
                    mwfcd_pkg::PH_UNLOCK: begin
                        cmd.owner_clr = sts.found && sts.own_is_root;
                    end
                    default: begin
                    end
                endcase
            end
            mwfcd_pkg::ST_EMIT: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cmp_after_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mwfcd_pkg::ST_SCMP |-> $past(state_reg) == mwfcd_pkg::ST_SADDR)
        else $error("compare step without a preceding read");
    a_write_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wait_write || cmd.owner_write |-> sts.found || sts.free_found)
        else $error("table write with neither a hit nor a free entry");
    a_emit_from_act: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == mwfcd_pkg::ST_EMIT) |-> $past(state_reg) == mwfcd_pkg::ST_ACT)
        else $error("result beats started outside a closed walk");
`endif

endmodule

/* hw/rtl/mutex_wait_for_cycle_detector.sv */
// Top level: a mutex wait-for graph tracker that reports closed wait cycles.
// A table lookup scans its RAM up to the first hit: a free entry is skipped once its valid
// bit is seen, a used one is read and then compared, and the hit is then acted on. Lock exit
// and unlock take one or two lookups; lock enter takes up to 2*min(HOP_LIMIT+1,7) lookups,
// then emits one result beat per cycle while m_ready is high.
// Synchronous active-low reset clears the valid bits, the target register, the counters and the controller.
module mutex_wait_for_cycle_detector #(
    parameter int OWNER_ENTRIES = 64,
    parameter int WAIT_ENTRIES  = 64,
    parameter int HOP_LIMIT     = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_target_process,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_thread_id,
    input  logic [31:0] s_process_id,
    input  logic [63:0] s_mutex_addr,
    input  logic        s_lock_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_root_thread,
    output logic [31:0] m_report_process,
    output logic [2:0]  m_chain_depth,
    output logic [2:0]  m_hop_index,
    output logic [31:0] m_hop_thread,
    output logic [63:0] m_hop_mutex,
    output logic        m_last
);

    mwfcd_pkg::cmd_t cmd;
    mwfcd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    mwfcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mwfcd_datapath #(
        .OWNER_ENTRIES (OWNER_ENTRIES),
        .WAIT_ENTRIES  (WAIT_ENTRIES),
        .HOP_LIMIT     (HOP_LIMIT)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_valid          (cfg_valid),
        .cfg_target_process (cfg_target_process),
        .s_kind             (s_kind),
        .s_thread_id        (s_thread_id),
        .s_process_id       (s_process_id),
        .s_mutex_addr       (s_mutex_addr),
        .s_lock_ok          (s_lock_ok),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_root_thread      (m_root_thread),
        .m_report_process   (m_report_process),
        .m_chain_depth      (m_chain_depth),
        .m_hop_index        (m_hop_index),
        .m_hop_thread       (m_hop_thread),
        .m_hop_mutex        (m_hop_mutex),
        .m_last             (m_last)
    );

endmodule
